// File: hdl/set_assoc_cache_lru_directory_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LRU cache directory
// Immediate-consequence and next-cycle property checks; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_DIRECTORY_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_DIRECTORY_MACROS_SVH
`ifndef SYNTH
// consequence holds in the same cycle as the antecedent
`define SALD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// consequence holds in the cycle after the antecedent
`define SALD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SALD_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SALD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/sald_pkg.sv
// ----------------------------------------------------------------------------
// sald_pkg
// Shared widths, register codes, item and result types of the cache directory.
// ----------------------------------------------------------------------------
package sald_pkg;

   // field widths
   localparam int ADDR_W        = 31;
   localparam int TAG_W         = 31;
   localparam int STAMP_W       = 32;
   localparam int ENTRY_W       = 1 + TAG_W + STAMP_W;
   localparam int MAX_SET_W     = 12;
   localparam int WORD_OFFSET_W = 16;
   localparam int RSP_WAY_W     = 2;
   localparam int RSP_SET_W     = 6;

   // configuration registers
   localparam int OFFSET_BITS_W   = 5;
   localparam int INDEX_BITS_W    = 3;
   localparam int MAX_OFFSET_BITS = 16;
   localparam int CSR_DATA_W      = 5;
   localparam int CSR_IDX_W       = 1;
   localparam logic [OFFSET_BITS_W-1:0] OFFSET_BITS_RESET = 5'd4;
   localparam logic [INDEX_BITS_W-1:0]  INDEX_BITS_RESET  = 3'd6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET_BITS = 1'b0,
      CSR_INDEX_BITS  = 1'b1
   } csr_index_type;

   // geometry defaults and queue depth
   localparam int DEFAULT_WAYS = 4;
   localparam int DEFAULT_SETS = 64;
   localparam int QUEUE_DEPTH  = 2;

   // classified lookup item
   typedef struct packed {
      logic [TAG_W-1:0]         tag;
      logic [MAX_SET_W-1:0]     set;
      logic [WORD_OFFSET_W-1:0] word_offset;
      logic [ADDR_W-1:0]        line_start;
   } item_type;

   // one lookup result
   typedef struct packed {
      logic                     hit;
      logic [RSP_WAY_W-1:0]     way;
      logic [RSP_SET_W-1:0]     set_index;
      logic [WORD_OFFSET_W-1:0] word_offset;
      logic [ADDR_W-1:0]        refill_address;
   } result_type;

   // lookup engine states
   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOKUP
   } back_state_type;

endpackage

// File: hdl/sald_front.sv
// ----------------------------------------------------------------------------
// sald_front
// Holds the field-width registers and splits an address into offset, set, tag.
// ----------------------------------------------------------------------------
module sald_front #(
   parameter int SETS = sald_pkg::DEFAULT_SETS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [sald_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sald_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [sald_pkg::ADDR_W-1:0]      req_address,
   output sald_pkg::item_type               item
);
   import sald_pkg::*;

   // widest usable index field: floor(log2(SETS))
   localparam int IDX_LIM  = $clog2(SETS + 1) - 1;
   localparam int IB_CMP_W = INDEX_BITS_W + 1;
   localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

   logic [OFFSET_BITS_W-1:0] offset_bits_ff, offset_bits_in;
   logic [INDEX_BITS_W-1:0]  index_bits_ff, index_bits_in;
   logic [OFFSET_BITS_W-1:0] ob;
   logic [IB_CMP_W-1:0]      ib_cmp;
   logic [INDEX_BITS_W-1:0]  ib;
   logic [OFFSET_BITS_W-1:0] shift;
   logic [ADDR_W-1:0]        off_mask;
   logic [ADDR_W-1:0]        off_full;
   logic [ADDR_W-1:0]        set_full;

   // register writes
   always_comb begin
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_OFFSET_BITS: offset_bits_in = csr_wdata;
            CSR_INDEX_BITS:  index_bits_in  = csr_wdata[INDEX_BITS_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFFSET_BITS_RESET;
         index_bits_ff  <= INDEX_BITS_RESET;
      end else begin
         offset_bits_ff <= offset_bits_in;
         index_bits_ff  <= index_bits_in;
      end
   end

   // clamp field widths to what the geometry allows
   always_comb begin
      ob = (offset_bits_ff > OFFSET_BITS_W'(MAX_OFFSET_BITS)) ?
           OFFSET_BITS_W'(MAX_OFFSET_BITS) : offset_bits_ff;
      ib_cmp = ({1'b0, index_bits_ff} > IB_CMP_W'(IDX_LIM)) ?
               IB_CMP_W'(IDX_LIM) : {1'b0, index_bits_ff};
      ib    = ib_cmp[INDEX_BITS_W-1:0];
      shift = ob + OFFSET_BITS_W'(ib);
   end

   // address split
   always_comb begin
      off_mask         = ~(ADDR_ONES << ob);
      off_full         = req_address & off_mask;
      set_full         = (req_address >> ob) & ~(ADDR_ONES << ib);
      item.tag         = req_address >> shift;
      item.set         = set_full[MAX_SET_W-1:0];
      item.word_offset = off_full[WORD_OFFSET_W-1:0];
      item.line_start  = req_address & ~off_mask;
   end

endmodule

// File: hdl/sald_queue.sv
// ----------------------------------------------------------------------------
// sald_queue
// Short FIFO of classified items between the front and the lookup engine.
// ----------------------------------------------------------------------------
module sald_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sald_pkg::item_type push_item,
   input  logic               pop,
   output sald_pkg::item_type head,
   output logic               empty,
   output logic               full
);
   import sald_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head  = slot_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(DEPTH));

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/sald_back.sv
// ----------------------------------------------------------------------------
// sald_back
// Lookup engine: clearing pass after reset, then set read, tag match, LRU victim choice and row write-back.
// ----------------------------------------------------------------------------
module sald_back #(
   parameter int WAYS = sald_pkg::DEFAULT_WAYS,
   parameter int SETS = sald_pkg::DEFAULT_SETS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  sald_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 clearing,
   output logic                 rsp_valid,
   output sald_pkg::result_type rsp
);
   import sald_pkg::*;

   localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LVLS   = $clog2(WAYS);
   localparam int LEAVES = 1 << LVLS;
   localparam int ROW_W  = WAYS * ENTRY_W;
   localparam int KEY_W  = STAMP_W + 1;

   back_state_type       state_ff, state_in;
   logic [SET_W-1:0]     clear_ptr_ff, clear_ptr_in;
   item_type             item_ff, item_in;
   logic [STAMP_W-1:0]   counter_ff, counter_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_ff, rsp_in;

   // set memory: one row holds valid, tag and stamp of every way
   logic [ROW_W-1:0]     row_ram [SETS];
   logic [ROW_W-1:0]     row_rd_ff;
   logic [SET_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [SET_W-1:0]     wr_addr;
   logic [ROW_W-1:0]     wr_data;

   logic                 way_valid [WAYS];
   logic [TAG_W-1:0]     way_tag   [WAYS];
   logic [STAMP_W-1:0]   way_stamp [WAYS];
   logic [WAYS-1:0]      match;
   logic                 hit;
   logic [WAY_W-1:0]     hit_way;
   logic [KEY_W-1:0]     key_lv [LVLS+1][LEAVES];
   logic [WAY_W-1:0]     idx_lv [LVLS+1][LEAVES];
   logic [WAY_W-1:0]     victim_way;
   logic [WAY_W-1:0]     pick;
   logic [31:0]          pick_ext;
   logic [ROW_W-1:0]     new_row;

   assign rd_addr = q_item.set[SET_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_ram[wr_addr] <= wr_data;
      end
      row_rd_ff <= row_ram[rd_addr];
   end

   // unpack the row and look for a matching tag, lowest way first
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         way_valid[w] = row_rd_ff[w*ENTRY_W + ENTRY_W - 1];
         way_tag[w]   = row_rd_ff[w*ENTRY_W + STAMP_W +: TAG_W];
         way_stamp[w] = row_rd_ff[w*ENTRY_W +: STAMP_W];
         match[w]     = way_valid[w] && (way_tag[w] == item_ff.tag);
      end
      hit     = |match;
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_W'(w);
         end
      end
   end

   // victim tree: invalid ways key as zero, lower way wins ties
   always_comb begin
      for (int l = 0; l <= LVLS; l++) begin
         for (int i = 0; i < LEAVES; i++) begin
            key_lv[l][i] = '0;
            idx_lv[l][i] = '0;
         end
      end
      for (int i = 0; i < WAYS; i++) begin
         key_lv[0][i] = way_valid[i] ? {1'b1, way_stamp[i]} : '0;
         idx_lv[0][i] = WAY_W'(i);
      end
      for (int i = WAYS; i < LEAVES; i++) begin
         key_lv[0][i] = '1;
         idx_lv[0][i] = WAY_W'(i);
      end
      for (int l = 0; l < LVLS; l++) begin
         for (int i = 0; i < (LEAVES >> (l + 1)); i++) begin
            if (key_lv[l][2*i+1] < key_lv[l][2*i]) begin
               key_lv[l+1][i] = key_lv[l][2*i+1];
               idx_lv[l+1][i] = idx_lv[l][2*i+1];
            end else begin
               key_lv[l+1][i] = key_lv[l][2*i];
               idx_lv[l+1][i] = idx_lv[l][2*i];
            end
         end
      end
      victim_way = idx_lv[LVLS][0];
   end

   // updated row: chosen way becomes valid with the item tag and current stamp
   always_comb begin
      pick     = hit ? hit_way : victim_way;
      pick_ext = 32'(pick);
      new_row  = row_rd_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == pick) begin
            new_row[w*ENTRY_W +: ENTRY_W] = {1'b1, item_ff.tag, counter_ff};
         end
      end
   end

   // sequencer: clearing pass, then read / compare-and-write per item
   always_comb begin
      state_in     = state_ff;
      clear_ptr_in = clear_ptr_ff;
      item_in      = item_ff;
      counter_in   = counter_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      clearing     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = clear_ptr_ff;
      wr_data      = '0;
      unique case (state_ff)
         BK_CLEAR: begin
            clearing = 1'b1;
            wr_en    = 1'b1;
            if (clear_ptr_ff == SET_W'(SETS - 1)) begin
               state_in = BK_IDLE;
            end else begin
               clear_ptr_in = clear_ptr_ff + 1'b1;
            end
         end
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               item_in  = q_item;
               state_in = BK_LOOKUP;
            end
         end
         BK_LOOKUP: begin
            wr_en                 = 1'b1;
            wr_addr               = item_ff.set[SET_W-1:0];
            wr_data               = new_row;
            rsp_valid_in          = 1'b1;
            rsp_in.hit            = hit;
            rsp_in.way            = pick_ext[RSP_WAY_W-1:0];
            rsp_in.set_index      = item_ff.set[RSP_SET_W-1:0];
            rsp_in.word_offset    = item_ff.word_offset;
            rsp_in.refill_address = item_ff.line_start;
            counter_in            = counter_ff + 1'b1;
            state_in              = BK_IDLE;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clear_ptr_ff <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ptr_ff <= clear_ptr_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: hdl/set_assoc_cache_lru_directory.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_directory
// Tag directory of a set-associative cache with timestamp LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   An address is taken at a rising edge with start high and busy low. The
//   front splits it with the offset_bits / index_bits registers and queues it
//   (two entries); busy is high while that queue is full.
//   The lookup engine handles each item in two steps: the registered
//   read of the set row, then tag compare, LRU victim choice and the row
//   write-back. The rate is limited by the
//   read-modify-write of a set row: the next set read waits for the write-back.
//   With an empty queue an accepted item is queued, popped into the item and
//   set-row read registers and looked up; the registered rsp_valid is high for one cycle.
//   The receiver cannot stall; each result appears exactly once.
//   Registers are written through csr_wr_en / csr_index / csr_wdata; the user
//   changes them only while no item is in flight, which the block does not enforce.
//   After reset a clearing pass invalidates every set, one set row at a time;
//   busy stays high meanwhile, and register writes are taken as usual.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lru_directory_macros.svh"

module set_assoc_cache_lru_directory #(
   parameter int WAYS = sald_pkg::DEFAULT_WAYS,
   parameter int SETS = sald_pkg::DEFAULT_SETS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [sald_pkg::ADDR_W-1:0]         req_address,
   input  logic                                csr_wr_en,
   input  logic [sald_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sald_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [sald_pkg::RSP_WAY_W-1:0]      rsp_way,
   output logic [sald_pkg::RSP_SET_W-1:0]      rsp_set_index,
   output logic [sald_pkg::WORD_OFFSET_W-1:0]  rsp_word_offset,
   output logic [sald_pkg::ADDR_W-1:0]         rsp_refill_address
);
   import sald_pkg::*;

   item_type   front_item;
   item_type   q_head;
   logic       q_push;
   logic       q_pop;
   logic       q_empty;
   logic       q_full;
   logic       back_clearing;
   result_type rsp;

   // accept while the queue has room and the clearing pass is over
   assign busy   = q_full || back_clearing;
   assign q_push = start && !busy;

   sald_front #(
      .SETS (SETS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_address (req_address),
      .item        (front_item)
   );

   sald_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   sald_back #(
      .WAYS (WAYS),
      .SETS (SETS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_item    (q_head),
      .q_pop     (q_pop),
      .clearing  (back_clearing),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_hit            = rsp.hit;
   assign rsp_way            = rsp.way;
   assign rsp_set_index      = rsp.set_index;
   assign rsp_word_offset    = rsp.word_offset;
   assign rsp_refill_address = rsp.refill_address;

   // each lookup returns to idle before the next pop, so strobes never come back to back
   `SALD_ASSERT_NEXT(a_rsp_spacing, clock, reset, rsp_valid, !rsp_valid, "rsp_valid on two cycles in a row")
   // a result follows its queue pop through the lookup state and the result register
   `SALD_ASSERT_SAME(a_rsp_after_pop, clock, reset, rsp_valid, $past(q_pop, 2), "result without a pop two cycles earlier")
   // line start and word offset never share set bits
   `SALD_ASSERT_SAME(a_line_split, clock, reset, rsp_valid, ((rsp_refill_address[15:0] & rsp_word_offset) == 16'd0), "line start overlaps word offset")

endmodule

// File: sim/tb_set_assoc_cache_lru_directory.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_cache_lru_directory
// Self-checking bench for the LRU cache directory. A directed table covers
// first fills, hits, LRU eviction and the field width limits. Random phases
// follow, each under its own offset/index setting. Every accepted address runs
// through a local copy of the directory, and each result strobe is compared
// field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_set_assoc_cache_lru_directory;
   import sald_pkg::*;

   localparam int DIR_WAYS      = DEFAULT_WAYS;
   localparam int DIR_SETS      = DEFAULT_SETS;
   localparam int SET_BITS      = $clog2(DIR_SETS);
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 56;
   localparam int DIRECTED_ROWS = 22;

   typedef enum logic {
      STEP_LOOKUP,
      STEP_CONFIG
   } step_kind_type;

   // one row of the directed table; exp is used only when fixed is set
   typedef struct {
      step_kind_type    kind;
      logic [ADDR_W-1:0] addr;
      logic [CSR_DATA_W-1:0] offset_wdata;
      logic [CSR_DATA_W-1:0] index_wdata;
      bit               fixed;
      result_type       exp;
   } directed_row_type;

   localparam result_type NO_RESULT = '0;

   // DUT connections; the inputs are known from time zero
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [ADDR_W-1:0]        req_address = '0;
   logic                     csr_wr_en = 1'b0;
   csr_index_type            csr_index = CSR_OFFSET_BITS;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                     rsp_valid;
   logic                     rsp_hit;
   logic [RSP_WAY_W-1:0]     rsp_way;
   logic [RSP_SET_W-1:0]     rsp_set_index;
   logic [WORD_OFFSET_W-1:0] rsp_word_offset;
   logic [ADDR_W-1:0]        rsp_refill_address;

   // local copy of the directory and its registers
   logic [OFFSET_BITS_W-1:0] cfg_offset_bits = OFFSET_BITS_RESET;
   logic [INDEX_BITS_W-1:0]  cfg_index_bits = INDEX_BITS_RESET;
   bit                       dir_valid [DIR_SETS*DIR_WAYS];
   logic [31:0]              dir_tag [DIR_SETS*DIR_WAYS];
   logic [31:0]              dir_stamp [DIR_SETS*DIR_WAYS];
   logic [31:0]              access_count = '0;

   result_type               due_results [$];
   int                       error_count = 0;
   int                       cycle_count = 0;
   bit                       steady_sender = 1'b0;

   // directed stimulus: fills, hits, LRU victim, width limits
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{STEP_LOOKUP, 31'h0000_0000, 5'd0, 5'd0, 1'b1,
        '{1'b0, 2'd0, 6'd0, 16'h0, 31'h0000_0000}},
      '{STEP_LOOKUP, 31'h0000_0000, 5'd0, 5'd0, 1'b1,
        '{1'b1, 2'd0, 6'd0, 16'h0, 31'h0000_0000}},
      '{STEP_LOOKUP, 31'h7FFF_FFFF, 5'd0, 5'd0, 1'b1,
        '{1'b0, 2'd0, 6'd63, 16'hF, 31'h7FFF_FFF0}},
      '{STEP_LOOKUP, 31'h7FFF_FFFF, 5'd0, 5'd0, 1'b1,
        '{1'b1, 2'd0, 6'd63, 16'hF, 31'h7FFF_FFF0}},
      '{STEP_LOOKUP, 31'h0000_0400, 5'd0, 5'd0, 1'b1,
        '{1'b0, 2'd1, 6'd0, 16'h0, 31'h0000_0400}},
      '{STEP_LOOKUP, 31'h0000_0800, 5'd0, 5'd0, 1'b1,
        '{1'b0, 2'd2, 6'd0, 16'h0, 31'h0000_0800}},
      '{STEP_LOOKUP, 31'h0000_0C00, 5'd0, 5'd0, 1'b1,
        '{1'b0, 2'd3, 6'd0, 16'h0, 31'h0000_0C00}},
      '{STEP_LOOKUP, 31'h0000_1000, 5'd0, 5'd0, 1'b0, NO_RESULT},
      '{STEP_LOOKUP, 31'h0000_0805, 5'd0, 5'd0, 1'b0, NO_RESULT},
      '{STEP_LOOKUP, 31'h0000_0003, 5'd0, 5'd0, 1'b0, NO_RESULT},
      '{STEP_LOOKUP, 31'h0000_0C0A, 5'd0, 5'd0, 1'b0, NO_RESULT},
      // no offset, single set: tag is the whole address
      '{STEP_CONFIG, 31'h0, 5'd0, 5'd0, 1'b0, NO_RESULT},
      '{STEP_LOOKUP, 31'h5555_5555, 5'd0, 5'd0, 1'b0, NO_RESULT},
      '{STEP_LOOKUP, 31'h2AAA_AAAA, 5'd0, 5'd0, 1'b0, NO_RESULT},
      '{STEP_LOOKUP, 31'h7FFF_FFFF, 5'd0, 5'd0, 1'b0, NO_RESULT},
      '{STEP_LOOKUP, 31'h5555_5555, 5'd0, 5'd0, 1'b0, NO_RESULT},
      // both registers beyond their limits, upper data bits set
      '{STEP_CONFIG, 31'h0, 5'd31, 5'd31, 1'b0, NO_RESULT},
      '{STEP_LOOKUP, 31'h7FFF_FFFF, 5'd0, 5'd0, 1'b0, NO_RESULT},
      '{STEP_LOOKUP, 31'h0001_FFFF, 5'd0, 5'd0, 1'b0, NO_RESULT},
      '{STEP_CONFIG, 31'h0, 5'd17, 5'd3, 1'b0, NO_RESULT},
      '{STEP_LOOKUP, 31'h3ABC_DEF1, 5'd0, 5'd0, 1'b0, NO_RESULT},
      '{STEP_LOOKUP, 31'h1234_5678, 5'd0, 5'd0, 1'b0, NO_RESULT}
   };

   set_assoc_cache_lru_directory dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_address        (req_address),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_hit            (rsp_hit),
      .rsp_way            (rsp_way),
      .rsp_set_index      (rsp_set_index),
      .rsp_word_offset    (rsp_word_offset),
      .rsp_refill_address (rsp_refill_address)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // effective field widths after clamping
   function automatic int unsigned eff_offset_bits();
      return (cfg_offset_bits > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : cfg_offset_bits;
   endfunction

   function automatic int unsigned eff_index_bits();
      return (cfg_index_bits > SET_BITS) ? SET_BITS : cfg_index_bits;
   endfunction

   // one lookup against the local directory; updates stamps, tags, counter
   function automatic result_type lookup_directory(input logic [ADDR_W-1:0] addr);
      int unsigned ob;
      int unsigned ib;
      int unsigned base;
      int unsigned pick;
      logic [31:0] wide_addr;
      logic [31:0] off_mask;
      logic [31:0] set_sel;
      logic [31:0] tag_val;
      logic [31:0] best;
      bit          matched;
      bit          vacant;
      result_type  r;
      ob = eff_offset_bits();
      ib = eff_index_bits();
      wide_addr = {1'b0, addr};
      off_mask = (32'd1 << ob) - 32'd1;
      set_sel = (wide_addr >> ob) & ((32'd1 << ib) - 32'd1);
      tag_val = wide_addr >> (ob + ib);
      base = set_sel * DIR_WAYS;
      matched = 1'b0;
      vacant = 1'b0;
      pick = 0;
      for (int w = 0; w < DIR_WAYS; w++) begin
         if (!matched && dir_valid[base+w] && dir_tag[base+w] == tag_val) begin
            matched = 1'b1;
            pick = w;
         end
      end
      if (matched) begin
         dir_stamp[base+pick] = access_count;
      end else begin
         // lowest invalid way first, else oldest stamp, lowest way on ties
         for (int w = 0; w < DIR_WAYS; w++) begin
            if (!vacant && !dir_valid[base+w]) begin
               vacant = 1'b1;
               pick = w;
            end
         end
         if (!vacant) begin
            best = '1;
            for (int w = 0; w < DIR_WAYS; w++) begin
               if (dir_stamp[base+w] < best) begin
                  best = dir_stamp[base+w];
                  pick = w;
               end
            end
         end
         dir_valid[base+pick] = 1'b1;
         dir_tag[base+pick] = tag_val;
         dir_stamp[base+pick] = access_count;
      end
      access_count = access_count + 32'd1;
      r.hit = matched;
      r.way = pick[RSP_WAY_W-1:0];
      r.set_index = set_sel[RSP_SET_W-1:0];
      r.word_offset = wide_addr[WORD_OFFSET_W-1:0] & off_mask[WORD_OFFSET_W-1:0];
      r.refill_address = wide_addr[ADDR_W-1:0] & ~off_mask[ADDR_W-1:0];
      return r;
   endfunction

   // present one address, wait for it to be taken, record its result
   task automatic issue_lookup(input logic [ADDR_W-1:0] addr, input bit fixed,
                               input result_type exp);
      result_type predicted;
      if (!steady_sender && $urandom_range(0, 99) < 18) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      req_address <= addr;
      do @(posedge clock); while (busy);
      predicted = lookup_directory(addr);
      due_results.push_back(fixed ? exp : predicted);
   endtask

   // stop sending and let every pending result come back
   task automatic drain_lookups();
      start <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers on consecutive edges
   task automatic write_directory_config(input logic [CSR_DATA_W-1:0] offset_wdata,
                                         input logic [CSR_DATA_W-1:0] index_wdata);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_OFFSET_BITS;
      csr_wdata <= offset_wdata;
      @(posedge clock);
      cfg_offset_bits = offset_wdata[OFFSET_BITS_W-1:0];
      csr_index <= CSR_INDEX_BITS;
      csr_wdata <= index_wdata;
      @(posedge clock);
      cfg_index_bits = index_wdata[INDEX_BITS_W-1:0];
      csr_wr_en <= 1'b0;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // result checker: the receiver never stalls, so every strobe is taken
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid) begin
         if (due_results.size() == 0) begin
            $error("unexpected result: refill_address 0x%0h", rsp_refill_address);
            error_count++;
         end else begin
            want = due_results.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_hit));
            check_field("way", 32'(want.way), 32'(rsp_way));
            check_field("set_index", 32'(want.set_index), 32'(rsp_set_index));
            check_field("word_offset", 32'(want.word_offset), 32'(rsp_word_offset));
            check_field("refill_address", 32'(want.refill_address),
                        32'(rsp_refill_address));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // main sequence
   initial begin
      logic [4:0]        phase_offset [PHASES];
      logic [2:0]        phase_index [PHASES];
      logic [31:0]       tag_pool [6];
      logic [31:0]       tag_val;
      logic [31:0]       set_val;
      logic [31:0]       off_val;
      logic [ADDR_W-1:0] addr;
      int unsigned       ob;
      int unsigned       ib;
      int unsigned       pick;

      foreach (dir_valid[i]) begin
         dir_valid[i] = 1'b0;
         dir_tag[i] = '0;
         dir_stamp[i] = '0;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == STEP_CONFIG) begin
            drain_lookups();
            write_directory_config(directed_rows[i].offset_wdata,
                                   directed_rows[i].index_wdata);
         end else begin
            issue_lookup(directed_rows[i].addr, directed_rows[i].fixed,
                         directed_rows[i].exp);
         end
      end

      // random phases: reset values, extremes, further fixed settings, then random settings
      phase_offset = '{5'd4, 5'd0, 5'd31, 5'd16, 5'd17, 5'd2, 5'd0, 5'd0};
      phase_index  = '{3'd6, 3'd0, 3'd7, 3'd6, 3'd1, 3'd3, 3'd0, 3'd0};
      phase_offset[6] = 5'($urandom_range(0, 31));
      phase_index[6]  = 3'($urandom_range(0, 7));
      phase_offset[7] = 5'($urandom_range(0, 12));
      phase_index[7]  = 3'($urandom_range(1, 6));

      for (int p = 0; p < PHASES; p++) begin
         drain_lookups();
         write_directory_config(phase_offset[p], {2'($urandom_range(0, 3)), phase_index[p]});
         // one phase with a sender that never pauses
         steady_sender = (p == 3);
         ob = eff_offset_bits();
         ib = eff_index_bits();
         foreach (tag_pool[t]) tag_pool[t] = $urandom;
         tag_pool[0] = '0;
         tag_pool[1] = '1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               // noise: any address
               addr = ADDR_W'($urandom);
            end else begin
               // few tags on few sets, so lines hit, age and get evicted
               tag_val = tag_pool[$urandom_range(0, 5)];
               set_val = (pick < 75) ? $urandom_range(0, 2) : $urandom;
               set_val = set_val & ((32'd1 << ib) - 32'd1);
               off_val = $urandom & ((32'd1 << ob) - 32'd1);
               addr = ADDR_W'((tag_val << (ob + ib)) | (set_val << ob) | off_val);
            end
            issue_lookup(addr, 1'b0, NO_RESULT);
         end
      end

      drain_lookups();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
